// File: src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, held off during reset.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Clocked assertion that also holds while reset is asserted.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: src/rpr_pkg.sv
// Package: constants, action codes and arctangent table for the rotary rotate block.
package rpr_pkg;

  localparam int MAX_PAIRS     = 128;
  localparam int POSITION_BITS = 17;
  localparam int SAMPLE_BITS   = 16;
  localparam int CORDIC_STAGES = 16;

  localparam int INDEX_BITS = 7;
  localparam int FREQ_BITS  = 32;
  localparam int GUARD_BITS = 16;
  localparam int QUEUE_DEPTH = 4;

  // 1/K CORDIC gain compensation, 0.32 fraction
  localparam logic [31:0] GAIN_K = 32'd2608131496;

  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_ROTATE = 1'b1;

  // atan(2^-i) in 0.32 turns
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

// File: src/rpr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rpr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/rpr_fifo.sv
// Short queue between the front end and the rotate pipeline.
module rpr_fifo #(
  parameter int WIDTH = 97,
  parameter int DEPTH = 4,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o,
  output logic             empty_o,
  output logic [CW-1:0]    count_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] buf_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_q] <= push_data_i;
    end
  end

  assign pop_data_o = buf_q[rd_q];
  assign empty_o    = (cnt_q == '0);
  assign count_o    = cnt_q;

endmodule

// File: src/rpr_front.sv
// Front end: takes beats, writes loads into the frequency table, queues rotates.
module rpr_front #(
  parameter int MAX_PAIRS     = rpr_pkg::MAX_PAIRS,
  parameter int POSITION_BITS = rpr_pkg::POSITION_BITS,
  parameter int SAMPLE_BITS   = rpr_pkg::SAMPLE_BITS,
  parameter int QUEUE_DEPTH   = rpr_pkg::QUEUE_DEPTH,
  parameter int CW            = $clog2(QUEUE_DEPTH + 1),
  parameter int EW            = POSITION_BITS + 2 * SAMPLE_BITS + rpr_pkg::FREQ_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                action_i,
  input  logic [rpr_pkg::INDEX_BITS-1:0]      pair_index_i,
  input  logic [POSITION_BITS-1:0]            position_i,
  input  logic signed [SAMPLE_BITS-1:0]       elem_low_i,
  input  logic signed [SAMPLE_BITS-1:0]       elem_high_i,
  input  logic [rpr_pkg::FREQ_BITS-1:0]       freq_turns_i,
  input  logic [CW-1:0]                       queue_count_i,
  output logic                                push_o,
  output logic [EW-1:0]                       push_data_o
);

  localparam int AW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
  localparam int FB = rpr_pkg::FREQ_BITS;

  logic                       accept;
  logic                       in_range;
  logic [17:0]                idx_w;
  logic [AW-1:0]              addr;
  logic                       wr_en;
  logic [FB-1:0]              rdata;
  logic                       fv_q;
  logic                       inr_q;
  logic [POSITION_BITS-1:0]   pos_q;
  logic [SAMPLE_BITS-1:0]     el_q, eh_q;
  logic [FB-1:0]              freq;

  // in-flight rotates must fit in the queue
  assign in_stall_o = ((32'(queue_count_i) + 32'(fv_q)) >= 32'(QUEUE_DEPTH));
  assign accept     = in_valid_i && !in_stall_o;

  assign idx_w    = 18'(pair_index_i);
  assign in_range = (32'(pair_index_i) < 32'(MAX_PAIRS));
  assign addr     = idx_w[AW-1:0];
  assign wr_en    = accept && (action_i == rpr_pkg::ACT_LOAD) && in_range;

  rpr_ram #(
    .WIDTH (FB),
    .DEPTH (MAX_PAIRS)
  ) u_freq_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (addr),
    .wdata_i (freq_turns_i),
    .raddr_i (addr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else begin
      fv_q <= accept && (action_i == rpr_pkg::ACT_ROTATE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      inr_q <= in_range;
      pos_q <= position_i;
      el_q  <= elem_low_i;
      eh_q  <= elem_high_i;
    end
  end

  // out-of-table index rotates by angle zero
  assign freq        = inr_q ? rdata : '0;
  assign push_o      = fv_q;
  assign push_data_o = {pos_q, el_q, eh_q, freq};

endmodule

// File: src/rpr_back.sv
// Back end: angle product, gain prescale, quadrant fold, CORDIC stages, saturation.
module rpr_back #(
  parameter int POSITION_BITS = rpr_pkg::POSITION_BITS,
  parameter int SAMPLE_BITS   = rpr_pkg::SAMPLE_BITS,
  parameter int CORDIC_STAGES = rpr_pkg::CORDIC_STAGES,
  parameter int EW            = POSITION_BITS + 2 * SAMPLE_BITS + rpr_pkg::FREQ_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          queue_empty_i,
  input  logic [EW-1:0]                 queue_data_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] rot_low_o,
  output logic signed [SAMPLE_BITS-1:0] rot_high_o
);

  localparam int W   = SAMPLE_BITS;
  localparam int FB  = rpr_pkg::FREQ_BITS;
  localparam int PRW = W + 33;             // prescale product
  localparam int XW  = W + 19;             // datapath with guard bits and growth
  localparam int RW  = XW - rpr_pkg::GUARD_BITS;
  localparam int N   = CORDIC_STAGES;
  localparam int MW  = POSITION_BITS + FB;

  logic                     adv;
  logic [POSITION_BITS-1:0] q_pos;
  logic [W-1:0]             q_el, q_eh;
  logic [FB-1:0]            q_freq;
  logic [MW-1:0]            ang_full;

  logic                     s0_v_q;
  logic [31:0]              a_q;
  logic signed [PRW-1:0]    px_q, py_q;

  logic signed [PRW-1:0]    px_r, py_r;
  logic signed [XW-1:0]     x0, y0, fx, fy;
  logic [31:0]              a_off;
  logic [1:0]               quad;
  logic [31:0]              z_raw;

  logic                     v_q [N+1];
  logic signed [XW-1:0]     x_q [N+1];
  logic signed [XW-1:0]     y_q [N+1];
  logic signed [32:0]       z_q [N+1];

  logic                     ov_q;
  logic signed [W-1:0]      ol_q, oh_q;

  // whole pipeline moves unless a finished result is held
  assign adv   = !(ov_q && out_stall_i);
  assign pop_o = adv && !queue_empty_i;

  assign {q_pos, q_el, q_eh, q_freq} = queue_data_i;
  assign ang_full = MW'(q_pos) * MW'(q_freq);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_q  <= ang_full[31:0];
      px_q <= $signed({{33{q_el[W-1]}}, q_el}) * $signed({{W{1'b0}}, 1'b0, rpr_pkg::GAIN_K});
      py_q <= $signed({{33{q_eh[W-1]}}, q_eh}) * $signed({{W{1'b0}}, 1'b0, rpr_pkg::GAIN_K});
    end
  end

  // round prescaled samples to 16 guard bits, fold the quadrant exactly
  always_comb begin
    px_r  = px_q + PRW'(32768);
    py_r  = py_q + PRW'(32768);
    x0    = {{2{px_r[PRW-1]}}, px_r[PRW-1:16]};
    y0    = {{2{py_r[PRW-1]}}, py_r[PRW-1:16]};
    a_off = a_q + 32'h20000000;
    quad  = a_off[31:30];
    z_raw = a_q - {quad, 30'b0};
    unique case (quad)
      2'd1: begin
        fx = -y0;
        fy = x0;
      end
      2'd2: begin
        fx = -x0;
        fy = -y0;
      end
      2'd3: begin
        fx = y0;
        fy = -x0;
      end
      default: begin
        fx = x0;
        fy = y0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
      for (int k = 0; k <= N; k++) begin
        v_q[k] <= 1'b0;
      end
      ov_q <= 1'b0;
    end else if (adv) begin
      s0_v_q <= pop_o;
      v_q[0] <= s0_v_q;
      for (int k = 0; k < N; k++) begin
        v_q[k+1] <= v_q[k];
      end
      ov_q <= v_q[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x_q[0] <= fx;
      y_q[0] <= fy;
      z_q[0] <= {z_raw[31], z_raw};
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [31:0] at;
    assign at = rpr_pkg::atan_turn(5'(i));
    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (!z_q[i][32]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - $signed({1'b0, at});
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + $signed({1'b0, at});
        end
      end
    end
  end

  function automatic logic signed [W-1:0] finish(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] t;
    logic signed [RW-1:0] r;
    logic signed [RW-1:0] hi;
    logic signed [RW-1:0] lo;
    t  = v + XW'(32768);
    r  = t[XW-1:16];
    hi = RW'((64'sd1 <<< (W - 1)) - 64'sd1);
    lo = -hi - RW'(1);
    if (r > hi) begin
      r = hi;
    end else if (r < lo) begin
      r = lo;
    end
    return r[W-1:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ol_q <= finish(x_q[N]);
      oh_q <= finish(y_q[N]);
    end
  end

  assign out_valid_o = ov_q;
  assign rot_low_o   = ol_q;
  assign rot_high_o  = oh_q;

endmodule

// File: src/rotary_position_rotate.sv
// Rotary position rotation of a half-split pair: table front end, CORDIC back end.
// Throughput: one beat per cycle, loads and rotates alike, while the output is taken.
// A rotate beat passes, in order, through the table read, the queue, the angle/prescale multiply,
// the quadrant fold, the CORDIC stages and the saturation register, then shows its result.
// Reset clears control state only; the frequency table holds no valid data until loaded.
// Input stalls once queued beats plus the one in the table read reach the queue depth of four.
module rotary_position_rotate #(
  parameter int MAX_PAIRS     = rpr_pkg::MAX_PAIRS,
  parameter int POSITION_BITS = rpr_pkg::POSITION_BITS,
  parameter int SAMPLE_BITS   = rpr_pkg::SAMPLE_BITS,
  parameter int CORDIC_STAGES = rpr_pkg::CORDIC_STAGES
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           action_i,
  input  logic [rpr_pkg::INDEX_BITS-1:0] pair_index_i,
  input  logic [POSITION_BITS-1:0]       position_i,
  input  logic signed [SAMPLE_BITS-1:0]  elem_low_i,
  input  logic signed [SAMPLE_BITS-1:0]  elem_high_i,
  input  logic [rpr_pkg::FREQ_BITS-1:0]  freq_turns_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]  rot_low_o,
  output logic signed [SAMPLE_BITS-1:0]  rot_high_o
);

  localparam int DEPTH = rpr_pkg::QUEUE_DEPTH;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int EW    = POSITION_BITS + 2 * SAMPLE_BITS + rpr_pkg::FREQ_BITS;

  logic          push, pop, empty;
  logic [EW-1:0] push_data, pop_data;
  logic [CW-1:0] count;

  rpr_front #(
    .MAX_PAIRS     (MAX_PAIRS),
    .POSITION_BITS (POSITION_BITS),
    .SAMPLE_BITS   (SAMPLE_BITS),
    .QUEUE_DEPTH   (DEPTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .pair_index_i  (pair_index_i),
    .position_i    (position_i),
    .elem_low_i    (elem_low_i),
    .elem_high_i   (elem_high_i),
    .freq_turns_i  (freq_turns_i),
    .queue_count_i (count),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  rpr_fifo #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty),
    .count_o     (count)
  );

  rpr_back #(
    .POSITION_BITS (POSITION_BITS),
    .SAMPLE_BITS   (SAMPLE_BITS),
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .queue_empty_i (empty),
    .queue_data_i  (pop_data),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .rot_low_o     (rot_low_o),
    .rot_high_o    (rot_high_o)
  );

endmodule

// File: src/rpr_checker.sv
// Port-level checker for the rotary rotate block, with its bind.
`include "assert_macros.svh"

module rpr_checker #(
  parameter int SAMPLE_BITS = rpr_pkg::SAMPLE_BITS,
  parameter int LIMIT       = rpr_pkg::CORDIC_STAGES + rpr_pkg::QUEUE_DEPTH + 8
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_stall_o,
  input logic                   action_i,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic [SAMPLE_BITS-1:0] rot_low_o,
  input logic [SAMPLE_BITS-1:0] rot_high_o
);

  logic       rot_beat, out_beat;
  logic [7:0] pend_q, pend_d;

  assign rot_beat = in_valid_i && !in_stall_o && (action_i == rpr_pkg::ACT_ROTATE);
  assign out_beat = out_valid_o && !out_stall_i;

  always_comb begin
    pend_d = pend_q + 8'(rot_beat) - 8'(out_beat);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(rot_low_o) && $stable(rot_high_o), "stalled result changed")
  `ASSERT_CLK(a_no_invent, clk_i, rst_ni, out_valid_o |-> pend_q != 8'd0, "result without pending rotate")
  `ASSERT_CLK(a_pend_bound, clk_i, rst_ni, 32'(pend_q) <= LIMIT, "too many rotates in flight")
  // reset seen at an edge leaves the output idle by the next edge
  `ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |=> !out_valid_o, "result valid during reset")

endmodule

bind rotary_position_rotate rpr_checker u_rpr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .action_i    (action_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .rot_low_o   (rot_low_o),
  .rot_high_o  (rot_high_o)
);
